// ===== hdl/grid_raycast_column_renderer_top_defines.svh =====
// Assertion macros shared by the checker module of the ray caster.
// Included by the checker file only.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_TOP_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_TOP_DEFINES_SVH
// Implication checked at every rising edge outside reset.
`define GRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked at every rising edge outside reset.
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/grc_pkg.sv =====
// Package of the grid ray caster: sizes, character codes, sine table and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;
    localparam int MAP_ROWS = 16;

    // Character codes of the result items.
    localparam logic [3:0] CH_BLANK  = 4'd0;
    localparam logic [3:0] CH_FULL   = 4'd1;
    localparam logic [3:0] CH_DARK   = 4'd2;
    localparam logic [3:0] CH_MEDIUM = 4'd3;
    localparam logic [3:0] CH_LIGHT  = 4'd4;
    localparam logic [3:0] CH_HASH   = 4'd5;
    localparam logic [3:0] CH_X      = 4'd6;
    localparam logic [3:0] CH_DOT    = 4'd7;
    localparam logic [3:0] CH_DASH   = 4'd8;

    // Request types.
    localparam logic REQ_MAP  = 1'b0;
    localparam logic REQ_CAST = 1'b1;

    // Register addresses (word index).
    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_FOV   = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;
    localparam logic [1:0] REG_STEP  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the cast item, start angle division
        logic div_step;  // one restoring-division step for the angle
        logic set_dir;   // form the angle and read the sine table
        logic march;     // one march step
        logic corner;    // evaluate one corner (index in corner_idx)
        logic [1:0] corner_idx;
        logic cdiv_start; // start ceiling division
        logic cdiv_step;  // one ceiling division step
        logic emit_first; // start the row counter
        logic emit_next;  // advance to next row
    } grc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic march_done;
        logic cdiv_done;
        logic last_row;
    } grc_stat_t;

    // Quarter-wave sine table, 4096 scale.
    function automatic logic [12:0] sine_q(input logic [6:0] k);
        logic [12:0] v;
        case (k)
            7'd0: v = 13'd0;     7'd1: v = 13'd101;   7'd2: v = 13'd201;
            7'd3: v = 13'd301;   7'd4: v = 13'd401;   7'd5: v = 13'd501;
            7'd6: v = 13'd601;   7'd7: v = 13'd700;   7'd8: v = 13'd799;
            7'd9: v = 13'd897;   7'd10: v = 13'd995;  7'd11: v = 13'd1092;
            7'd12: v = 13'd1189; 7'd13: v = 13'd1285; 7'd14: v = 13'd1380;
            7'd15: v = 13'd1474; 7'd16: v = 13'd1567; 7'd17: v = 13'd1660;
            7'd18: v = 13'd1751; 7'd19: v = 13'd1842; 7'd20: v = 13'd1931;
            7'd21: v = 13'd2019; 7'd22: v = 13'd2106; 7'd23: v = 13'd2191;
            7'd24: v = 13'd2276; 7'd25: v = 13'd2359; 7'd26: v = 13'd2440;
            7'd27: v = 13'd2520; 7'd28: v = 13'd2598; 7'd29: v = 13'd2675;
            7'd30: v = 13'd2751; 7'd31: v = 13'd2824; 7'd32: v = 13'd2896;
            7'd33: v = 13'd2967; 7'd34: v = 13'd3035; 7'd35: v = 13'd3102;
            7'd36: v = 13'd3166; 7'd37: v = 13'd3229; 7'd38: v = 13'd3290;
            7'd39: v = 13'd3349; 7'd40: v = 13'd3406; 7'd41: v = 13'd3461;
            7'd42: v = 13'd3513; 7'd43: v = 13'd3564; 7'd44: v = 13'd3612;
            7'd45: v = 13'd3659; 7'd46: v = 13'd3703; 7'd47: v = 13'd3745;
            7'd48: v = 13'd3784; 7'd49: v = 13'd3822; 7'd50: v = 13'd3857;
            7'd51: v = 13'd3889; 7'd52: v = 13'd3920; 7'd53: v = 13'd3948;
            7'd54: v = 13'd3973; 7'd55: v = 13'd3996; 7'd56: v = 13'd4017;
            7'd57: v = 13'd4036; 7'd58: v = 13'd4052; 7'd59: v = 13'd4065;
            7'd60: v = 13'd4076; 7'd61: v = 13'd4085; 7'd62: v = 13'd4091;
            7'd63: v = 13'd4095; 7'd64: v = 13'd4096;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // Signed sine of a binary angle, Q1.12.
    function automatic logic signed [13:0] sin_lookup(input logic [15:0] a);
        logic [1:0] q;
        logic [5:0] k;
        logic [12:0] m;
        q = a[15:14];
        k = a[13:8];
        m = q[0] ? sine_q(7'd64 - {1'b0, k}) : sine_q({1'b0, k});
        return q[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction
endpackage
`default_nettype wire

// ===== hdl/grc_stream_if.sv =====
// Valid/ready stream interface with a parameterized payload type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface grc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/grc_ctrl.sv =====
// Controller state machine of the ray caster: sequences angle division, march,
// corner tests, ceiling division and row emission. Depends on grc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module grc_ctrl
    import grc_pkg::*;
#(
    parameter int DIV_STEPS = 23
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cast_valid,
    output logic           cast_ready,
    input  wire logic      out_ready,
    output logic           out_valid,
    output grc_cmd_t       cmd,
    input  grc_stat_t      stat
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_ADIV   = 8'b00000010,
        S_DIR    = 8'b00000100,
        S_MARCH  = 8'b00001000,
        S_CORNER = 8'b00010000,
        S_CDIV   = 8'b00100000,
        S_EMIT   = 8'b01000000,
        S_WAIT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cast_ready = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cast_ready = 1'b1;
                if (cast_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = S_DIR;
            end
            S_DIR:
            begin
                cmd.set_dir = 1'b1;
                state_next  = S_MARCH;
            end
            S_MARCH:
            begin
                if (stat.march_done)
                begin
                    cnt_next   = '0;
                    state_next = S_CORNER;
                end
                else
                    cmd.march = 1'b1;
            end
            S_CORNER:
            begin
                cmd.corner     = 1'b1;
                cmd.corner_idx = cnt_reg[1:0];
                cnt_next       = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cmd.cdiv_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_CDIV;
                end
            end
            S_CDIV:
            begin
                // The datapath counts its own division steps.
                if (stat.cdiv_done)
                    state_next = S_WAIT;
                else
                    cmd.cdiv_step = 1'b1;
            end
            S_WAIT:
            begin
                cmd.emit_first = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.last_row)
                        state_next = S_IDLE;
                    else
                        cmd.emit_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/grc_datapath.sv =====
// Datapath of the ray caster: map memory, angle divider, march unit, corner test,
// ceiling divider and row shader. Depends on grc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module grc_datapath
    import grc_pkg::*;
#(
    parameter int SCREEN_ROWS = 40,
    parameter int MAP_SIZE = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        map_we,
    input  wire logic [3:0]  map_row,
    input  wire logic [15:0] map_bits,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] view_angle,
    input  wire logic [6:0]  column,
    input  wire logic [7:0]  screen_width,
    input  wire logic [15:0] field_of_view,
    input  wire logic [4:0]  max_depth,
    input  wire logic [12:0] step_size,
    input  grc_cmd_t         cmd,
    output grc_stat_t        stat,
    output logic [5:0]       row,
    output logic [3:0]       char_code,
    output logic [16:0]      wall_distance,
    output logic             last
);
    localparam int RW = $clog2(SCREEN_ROWS);

    // Wall map, undefined until written.
    logic [15:0] map_mem [MAP_ROWS];
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_row] <= map_bits;
    end

    // Cast item capture.
    logic [15:0] px_reg, py_reg, view_reg;
    logic [16:0] dmax_reg;
    logic [12:0] step_reg;
    logic [15:0] half_fov_reg;
    // Angle division: col*fov / width, restoring.
    logic [22:0] quot_reg;     // dividend shifting into quotient
    logic [7:0]  den_reg;
    logic [8:0]  rem_reg;
    logic [8:0]  rem_try;

    always_comb
    begin
        rem_try = {rem_reg[7:0], quot_reg[22]} - {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg       <= pos_x;
            py_reg       <= pos_y;
            view_reg     <= view_angle;
            half_fov_reg <= {1'b0, field_of_view[15:1]};
            den_reg      <= (screen_width == 8'd0) ? 8'd1 : screen_width;
            quot_reg     <= {16'd0, column} * {7'd0, field_of_view};
            rem_reg      <= '0;
            dmax_reg     <= (max_depth == 5'd0) ? 17'd4096 :
                            (max_depth > 5'd16) ? 17'd65536 : {max_depth, 12'd0};
            step_reg     <= (step_size == 13'd0) ? 13'd1 :
                            (step_size > 13'd4096) ? 13'd4096 : step_size;
        end
        else if (cmd.div_step)
        begin
            if (!rem_try[8])
            begin
                rem_reg  <= rem_try;
                quot_reg <= {quot_reg[21:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[7:0], quot_reg[22]};
                quot_reg <= {quot_reg[21:0], 1'b0};
            end
        end
    end

    // 23-bit dividend needs 23 steps; extra leading steps come first.
    // Controller runs DIV_STEPS; the product is below 2^23.

    // Direction vector.
    logic [15:0] ang;
    logic signed [13:0] ex_reg, ey_reg;
    assign ang = view_reg - half_fov_reg + quot_reg[15:0];
    always_ff @(posedge clk)
    begin
        if (cmd.set_dir)
        begin
            ex_reg <= sin_lookup(ang);
            ey_reg <= sin_lookup(ang + 16'd16384);
        end
    end

    // March: dist advances; sample offsets tracked by accumulating e*step.
    logic [16:0] dist_reg;
    logic signed [31:0] ox_reg, oy_reg;   // e*dist, exact
    logic signed [31:0] ox_n, oy_n;
    logic signed [19:0] sx, sy;
    logic [3:0] cx, cy;
    logic hit_reg, wall_reg;
    logic [3:0] cellx_reg, celly_reg;
    logic [15:0] mrow;

    assign ox_n = ox_reg + ex_reg * $signed({1'b0, step_reg});
    assign oy_n = oy_reg + ey_reg * $signed({1'b0, step_reg});
    assign sx = $signed({4'd0, px_reg}) + 20'(ox_n >>> 12);
    assign sy = $signed({4'd0, py_reg}) + 20'(oy_n >>> 12);
    assign cx = sx[15:12];
    assign cy = sy[15:12];
    assign mrow = map_mem[cy];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            wall_reg <= 1'b0;
        end
        else if (cmd.set_dir)
        begin
            hit_reg  <= 1'b0;
            wall_reg <= 1'b0;
        end
        else if (cmd.march)
        begin
            if (sx < 0 || sy < 0 || sx[19:12] >= 8'(MAP_SIZE) ||
                sy[19:12] >= 8'(MAP_SIZE))
                hit_reg <= 1'b1;
            else if (mrow[cx])
            begin
                hit_reg  <= 1'b1;
                wall_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_dir)
        begin
            dist_reg <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end
        else if (cmd.march)
        begin
            ox_reg    <= ox_n;
            oy_reg    <= oy_n;
            cellx_reg <= cx;
            celly_reg <= cy;
            if (sx < 0 || sy < 0 || sx[19:12] >= 8'(MAP_SIZE) ||
                sy[19:12] >= 8'(MAP_SIZE))
                dist_reg <= dmax_reg;
            else
                dist_reg <= dist_reg + 17'(step_reg);
        end
    end
    assign stat.march_done = hit_reg || (dist_reg >= dmax_reg);

    // Corner distances, ranked; tested corners evaluated one per cycle.
    logic signed [17:0] vx [4];
    logic signed [17:0] vy [4];
    logic signed [35:0] sqx [4];
    logic signed [35:0] sqy [4];
    logic [35:0] d2 [4];
    logic [3:0] sel;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            vx[i] = $signed({1'b0, 17'({cellx_reg, 12'd0}) + 17'(i / 2) * 17'd4096})
                    - $signed({2'b0, px_reg});
            vy[i] = $signed({1'b0, 17'({celly_reg, 12'd0}) + 17'(i % 2) * 17'd4096})
                    - $signed({2'b0, py_reg});
            sqx[i] = vx[i] * vx[i];
            sqy[i] = vy[i] * vy[i];
            d2[i]  = $unsigned(sqx[i]) + $unsigned(sqy[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            int rank;
            rank = 0;
            for (int j = 0; j < 4; j++)
                if (d2[j] < d2[i] || (d2[j] == d2[i] && j < i))
                    rank++;
            sel[i] = (rank < 2);
        end
    end

    // Corner test pipeline. The angle test cross^2 <= (P-1)/10000 is done
    // as 10000*cross^2 < P, with P = |e|^2*|c|^2 built from two partial
    // products and 10000*cross^2 built from shifts.
    logic [1:0] ci;
    logic signed [31:0] dot_n, cr_n, cr_abs;
    logic signed [26:0] e2_n;
    logic signed [31:0] dot_reg;
    logic [29:0] cr_reg;
    logic [25:0] e2_reg;
    logic [33:0] c2_reg;
    logic sel_reg;
    logic [59:0] crsq_reg;
    logic [42:0] plo_reg, phi_reg;
    logic pos_reg;
    logic [59:0] p_reg;
    logic [73:0] lhs_reg;
    logic pos3_reg;
    logic t1_reg, t2_reg, t3_reg, bound_reg;

    assign ci     = cmd.corner_idx;
    assign dot_n  = ex_reg * vx[ci] + ey_reg * vy[ci];
    assign cr_n   = ex_reg * vy[ci] - ey_reg * vx[ci];
    assign cr_abs = (cr_n < 0) ? -cr_n : cr_n;
    assign e2_n   = ex_reg * ex_reg + ey_reg * ey_reg;

    always_ff @(posedge clk)
    begin
        // Stage one: dot and cross products of the selected corner.
        dot_reg  <= dot_n;
        cr_reg   <= cr_abs[29:0];
        e2_reg   <= e2_n[25:0];
        c2_reg   <= d2[ci][33:0];
        sel_reg  <= sel[ci] && wall_reg;
        // Stage two: squared cross product and the partial products of P.
        crsq_reg <= cr_reg * cr_reg;
        plo_reg  <= e2_reg * c2_reg[16:0];
        phi_reg  <= e2_reg * c2_reg[33:17];
        pos_reg  <= sel_reg && (dot_reg > 0);
        // Stage three: P and the scaled cross term.
        p_reg    <= {phi_reg, 17'd0} + {17'd0, plo_reg};
        lhs_reg  <= {1'b0, crsq_reg, 13'd0} + {4'd0, crsq_reg, 10'd0} +
                    {5'd0, crsq_reg, 9'd0} + {6'd0, crsq_reg, 8'd0} +
                    {10'd0, crsq_reg, 4'd0};
        pos3_reg <= pos_reg;
    end

    // Stage four: mark a boundary when a tested corner lines up with the ray.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg    <= 1'b0;
            t2_reg    <= 1'b0;
            t3_reg    <= 1'b0;
            bound_reg <= 1'b0;
        end
        else
        begin
            t1_reg <= cmd.corner;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            if (cmd.set_dir)
                bound_reg <= 1'b0;
            else if (t3_reg && pos3_reg && p_reg != 60'd0 && lhs_reg < {14'd0, p_reg})
                bound_reg <= 1'b1;
        end
    end

    // Ceiling division: (H*dist - 2*H*4096) / (2*dist), truncated toward zero.
    logic signed [24:0] cnum;
    logic [23:0] cq_reg;
    logic [17:0] cden_reg;
    logic [18:0] crem_reg, crem_try;
    logic cneg_reg;
    logic [4:0] cdiv_cnt_reg;
    assign cnum = $signed({1'b0, 24'(SCREEN_ROWS) * 24'(dist_reg)}) -
                  25'(2 * SCREEN_ROWS * 4096);
    assign crem_try = {crem_reg[17:0], cq_reg[23]} - {1'b0, cden_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.cdiv_start)
        begin
            cneg_reg     <= cnum[24];
            cq_reg       <= cnum[24] ? 24'(-cnum) : cnum[23:0];
            cden_reg     <= {dist_reg, 1'b0};
            crem_reg     <= '0;
            cdiv_cnt_reg <= '0;
        end
        else if (cmd.cdiv_step)
        begin
            cdiv_cnt_reg <= cdiv_cnt_reg + 5'd1;
            if (!crem_try[18])
            begin
                crem_reg <= crem_try;
                cq_reg   <= {cq_reg[22:0], 1'b1};
            end
            else
            begin
                crem_reg <= {crem_reg[17:0], cq_reg[23]};
                cq_reg   <= {cq_reg[22:0], 1'b0};
            end
        end
    end
    assign stat.cdiv_done = (cdiv_cnt_reg == 5'd24);

    // Row emission.
    logic signed [24:0] ceil_s, floor_s, r_s, m_s;
    logic [3:0] shade;
    logic [RW-1:0] row_reg;
    assign ceil_s  = cneg_reg ? -$signed({1'b0, cq_reg}) : $signed({1'b0, cq_reg});
    assign floor_s = 25'(SCREEN_ROWS) - ceil_s;
    assign r_s     = 25'(row_reg);
    assign m_s     = 25'(SCREEN_ROWS) - r_s;

    always_comb
    begin
        if ({dist_reg, 2'b0} <= {2'b0, dmax_reg})
            shade = CH_FULL;
        else if (19'(dist_reg) * 19'd3 < 19'(dmax_reg))
            shade = CH_DARK;
        else if ({dist_reg, 1'b0} < {1'b0, dmax_reg})
            shade = CH_MEDIUM;
        else if (dist_reg < dmax_reg)
            shade = CH_LIGHT;
        else
            shade = CH_BLANK;
        if (bound_reg)
            shade = CH_BLANK;
        if (r_s < ceil_s)
            char_code = CH_BLANK;
        else if (r_s <= floor_s)
            char_code = shade;
        else if (8 * m_s < SCREEN_ROWS)
            char_code = CH_HASH;
        else if (4 * m_s < SCREEN_ROWS)
            char_code = CH_X;
        else if (8 * m_s < 3 * SCREEN_ROWS)
            char_code = CH_DOT;
        else if (20 * m_s < 9 * SCREEN_ROWS)
            char_code = CH_DASH;
        else
            char_code = CH_BLANK;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_first)
            row_reg <= '0;
        else if (cmd.emit_next)
            row_reg <= row_reg + RW'(1);
    end
    assign stat.last_row = (row_reg == RW'(SCREEN_ROWS - 1));
    assign row           = 6'(row_reg);
    assign wall_distance = dist_reg;
    assign last          = stat.last_row;
endmodule
`default_nettype wire

// ===== hdl/grid_raycast_column_renderer_top.sv =====
// Ray caster top level: one cast item gives SCREEN_ROWS result items.
// A cast runs through angle division, direction setup, the march of n steps, where n
// is at most max_depth*4096/step_size rounded up (160 at reset values), the corner
// tests, ceiling division and row setup before the first result item. Then one
// result item per cycle while the receiver is ready; the next item is taken after
// the last row. Map writes are accepted only while idle. Reset (rst_n low,
// asynchronous) clears control and the configuration registers to defaults; the
// wall map is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module grid_raycast_column_renderer_top
    import grc_pkg::*;
#(
    parameter int SCREEN_ROWS = 40,
    parameter int MAP_SIZE = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    grc_stream_if.sink       in_ch,
    grc_stream_if.source     out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [7:0]  width_reg;
    logic [15:0] fov_reg;
    logic [4:0]  depth_reg;
    logic [12:0] step_reg;
    grc_cmd_t  cmd;
    grc_stat_t stat;
    logic cast_ready, is_cast, is_map;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 8'd120;
            fov_reg   <= 16'd8192;
            depth_reg <= 5'd16;
            step_reg  <= 13'd410;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_WIDTH: width_reg <= pwdata[7:0];
                REG_FOV:   fov_reg   <= pwdata[15:0];
                REG_DEPTH: depth_reg <= pwdata[4:0];
                REG_STEP:  step_reg  <= pwdata[12:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH: prdata = {24'd0, width_reg};
            REG_FOV:   prdata = {16'd0, fov_reg};
            REG_DEPTH: prdata = {27'd0, depth_reg};
            REG_STEP:  prdata = {19'd0, step_reg};
            default:   prdata = '0;
        endcase
    end

    // Map writes complete whenever idle; casts start the controller.
    assign in_ch.ready = cast_ready;
    assign is_cast = in_ch.valid && in_ch.payload.req_type == REQ_CAST;
    assign is_map  = in_ch.valid && cast_ready && in_ch.payload.req_type == REQ_MAP;

    grc_ctrl #(.DIV_STEPS(23)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cast_valid (is_cast),
        .cast_ready (cast_ready),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .cmd        (cmd),
        .stat       (stat)
    );

    grc_datapath #(.SCREEN_ROWS(SCREEN_ROWS), .MAP_SIZE(MAP_SIZE)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .map_we        (is_map),
        .map_row       (in_ch.payload.map_row),
        .map_bits      (in_ch.payload.map_bits),
        .pos_x         (in_ch.payload.pos_x),
        .pos_y         (in_ch.payload.pos_y),
        .view_angle    (in_ch.payload.view_angle),
        .column        (in_ch.payload.column),
        .screen_width  (width_reg),
        .field_of_view (fov_reg),
        .max_depth     (depth_reg),
        .step_size     (step_reg),
        .cmd           (cmd),
        .stat          (stat),
        .row           (out_ch.payload.row),
        .char_code     (out_ch.payload.char_code),
        .wall_distance (out_ch.payload.wall_distance),
        .last          (out_ch.payload.last)
    );
endmodule
`default_nettype wire

// ===== hdl/grc_checker.sv =====
// Port-level checker of the ray caster, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_raycast_column_renderer_top_defines.svh"
module grc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_last,
    input wire logic [5:0] out_row,
    input wire logic [3:0] out_code
);
    // No new item is taken while a column is being delivered.
    `GRC_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken during output")
    // A row after a non-final row follows in sequence.
    `GRC_ASSERT_NEXT(a_row_seq, out_valid && out_ready && !out_last,
        out_row == $past(out_row) + 6'd1, "row sequence broken")
    // The last row ends the column.
    `GRC_ASSERT_NEXT(a_last_end, out_valid && out_ready && out_last, !out_valid,
        "output continues after last row")
    // Character codes stay within the defined set.
    `GRC_ASSERT_IMP(a_code_range, out_valid, out_code <= 4'd8, "bad character code")
    // A stalled result stays valid and keeps its row.
    `GRC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_row),
        "stalled item changed")
endmodule

bind grid_raycast_column_renderer_top grc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.payload.last),
    .out_row   (out_ch.payload.row),
    .out_code  (out_ch.payload.char_code)
);
`default_nettype wire

// ===== dv/grc_tb_types.sv =====
// Item layouts of the ray caster streams as seen by the testbench.
// No dependencies; compiled before the testbench top.
`timescale 1ns / 1ps
package grc_tb_types;
    // One input item: a map row write or a column cast.
    typedef struct packed {
        logic        req_type;
        logic [3:0]  map_row;
        logic [15:0] map_bits;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] view_angle;
        logic [6:0]  column;
    } cast_req_t;

    // One result item: a single character of the rendered column.
    typedef struct packed {
        logic [5:0]  row;
        logic [3:0]  char_code;
        logic [16:0] wall_distance;
        logic        last;
    } column_char_t;
endpackage

// ===== dv/tb.sv =====
// Testbench top of the grid ray caster: drives map writes and casts, predicts
// every character of each column and compares. Depends on grc_pkg,
// grc_stream_if, grc_tb_types and the top level.
`timescale 1ns / 1ps
module tb;
    import grc_pkg::*;
    import grc_tb_types::*;

    localparam int ROWS = 40;
    localparam int CELLS = 16;
    localparam int STALL_LIMIT = 300000;

    // Column renderer prediction and the queue of characters still owed.
    class column_scoreboard;
        int unsigned width_r, fov_r, depth_r, step_r;
        logic [15:0] walls [16];
        column_char_t owed [$];
        int errors;
        int tab [65] = '{
            0, 101, 201, 301, 401, 501, 601, 700, 799, 897, 995, 1092, 1189, 1285,
            1380, 1474, 1567, 1660, 1751, 1842, 1931, 2019, 2106, 2191, 2276, 2359,
            2440, 2520, 2598, 2675, 2751, 2824, 2896, 2967, 3035, 3102, 3166, 3229,
            3290, 3349, 3406, 3461, 3513, 3564, 3612, 3659, 3703, 3745, 3784, 3822,
            3857, 3889, 3920, 3948, 3973, 3996, 4017, 4036, 4052, 4065, 4076, 4085,
            4091, 4095, 4096};

        function void set_reg(int idx, int unsigned v);
            case (idx)
                REG_WIDTH: width_r = v & 32'hFF;
                REG_FOV:   fov_r = v & 32'hFFFF;
                REG_DEPTH: depth_r = v & 32'h1F;
                REG_STEP:  step_r = v & 32'h1FFF;
                default: ;
            endcase
        endfunction

        function longint sine(logic [15:0] a);
            logic [1:0] q;
            logic [5:0] k;
            longint v;
            q = a[15:14];
            k = a[13:8];
            v = q[0] ? tab[64 - k] : tab[k];
            return q[1] ? -v : v;
        endfunction

        // A corner lies on the ray direction within about a hundredth of a radian.
        function bit on_corner(longint ex, longint ey, longint cx, longint cy);
            longint dotp;
            longint unsigned p, cr;
            dotp = ex * cx + ey * cy;
            p = longint'(ex * ex + ey * ey) * longint'(cx * cx + cy * cy);
            cr = (ex * cy - ey * cx) < 0 ? -(ex * cy - ey * cx) : (ex * cy - ey * cx);
            if (dotp <= 0 || p == 0)
                return 0;
            return cr * cr <= (p - 1) / 10000;
        endfunction

        // Notes an accepted item and queues the characters it produces.
        function void note_item(cast_req_t it);
            int unsigned w, dep, stp, col;
            logic [15:0] ang;
            longint ex, ey, px, py, ray_dist, dmax, sx, sy, cxl, cyl, ceil_r, floor_r, m;
            longint vx [4], vy [4], d2 [4];
            bit hit, edge_blank;
            int rank;
            logic [3:0] shade, code;
            column_char_t c;
            if (it.req_type == REQ_MAP)
            begin
                walls[it.map_row] = it.map_bits;
                return;
            end
            w = width_r == 0 ? 1 : width_r;
            dep = depth_r < 1 ? 1 : (depth_r > 16 ? 16 : depth_r);
            stp = step_r < 1 ? 1 : (step_r > 4096 ? 4096 : step_r);
            dmax = dep * 4096;
            col = it.column;
            ang = 16'(it.view_angle - fov_r / 2 + (col * fov_r) / w);
            ex = sine(ang);
            ey = sine(ang + 16'd16384);
            px = it.pos_x;
            py = it.pos_y;
            ray_dist = 0;
            hit = 0;
            edge_blank = 0;
            // March the ray until a wall, the map edge or the depth limit.
            while (!hit && ray_dist < dmax)
            begin
                ray_dist += stp;
                sx = px + ((ex * ray_dist) >>> 12);
                sy = py + ((ey * ray_dist) >>> 12);
                if (sx < 0 || sy < 0 || (sx >>> 12) >= CELLS || (sy >>> 12) >= CELLS)
                begin
                    hit = 1;
                    ray_dist = dmax;
                end
                else
                begin
                    cxl = sx >>> 12;
                    cyl = sy >>> 12;
                    if (walls[cyl][cxl])
                    begin
                        hit = 1;
                        for (int i = 0; i < 4; i++)
                        begin
                            vx[i] = (cxl + (i >> 1)) * 4096 - px;
                            vy[i] = (cyl + (i & 1)) * 4096 - py;
                            d2[i] = vx[i] * vx[i] + vy[i] * vy[i];
                        end
                        // Only the two nearest corners can blank the wall.
                        for (int i = 0; i < 4; i++)
                        begin
                            rank = 0;
                            for (int j = 0; j < 4; j++)
                                if (d2[j] < d2[i] || (d2[j] == d2[i] && j < i))
                                    rank++;
                            if (rank < 2 && on_corner(ex, ey, vx[i], vy[i]))
                                edge_blank = 1;
                        end
                    end
                end
            end
            ceil_r = (ROWS * ray_dist - 2 * ROWS * 4096) / (2 * ray_dist);
            floor_r = ROWS - ceil_r;
            if (4 * ray_dist <= dmax)       shade = CH_FULL;
            else if (3 * ray_dist < dmax)   shade = CH_DARK;
            else if (2 * ray_dist < dmax)   shade = CH_MEDIUM;
            else if (ray_dist < dmax)       shade = CH_LIGHT;
            else                            shade = CH_BLANK;
            if (edge_blank)
                shade = CH_BLANK;
            // One character per screen row, ceiling first.
            for (int r = 0; r < ROWS; r++)
            begin
                m = ROWS - r;
                if (r < ceil_r)                code = CH_BLANK;
                else if (r <= floor_r)         code = shade;
                else if (8 * m < ROWS)         code = CH_HASH;
                else if (4 * m < ROWS)         code = CH_X;
                else if (8 * m < 3 * ROWS)     code = CH_DOT;
                else if (20 * m < 9 * ROWS)    code = CH_DASH;
                else                           code = CH_BLANK;
                c.row = 6'(r);
                c.char_code = code;
                c.wall_distance = 17'(ray_dist);
                c.last = (r == ROWS - 1);
                owed = {owed, c};
            end
        endfunction

        function void check_char(column_char_t got);
            column_char_t exp_c;
            if (owed.size() == 0)
            begin
                $error("unexpected character row=%0d", got.row);
                errors++;
                return;
            end
            exp_c = owed.pop_front();
            if (got.row !== exp_c.row)
            begin
                $error("row: expected %0d, got %0d", exp_c.row, got.row);
                errors++;
            end
            if (got.char_code !== exp_c.char_code)
            begin
                $error("char_code: expected %0d, got %0d", exp_c.char_code, got.char_code);
                errors++;
            end
            if (got.wall_distance !== exp_c.wall_distance)
            begin
                $error("wall_distance: expected %0d, got %0d",
                       exp_c.wall_distance, got.wall_distance);
                errors++;
            end
            if (got.last !== exp_c.last)
            begin
                $error("last: expected %0d, got %0d", exp_c.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    grc_stream_if #(.payload_t(cast_req_t)) in_ch ();
    grc_stream_if #(.payload_t(column_char_t)) out_ch ();

    grid_raycast_column_renderer_top DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    column_scoreboard sb = new();
    int send_idle = 33;
    int recv_idle = 46;
    int stall_cycles = 0;
    int sent = 0;

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.payload = '0;
        out_ch.ready = 0;
    end

    // Receiver: random back-pressure and the result check.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_char(out_ch.payload);
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic reg_write(int idx, int unsigned v);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= 4'(idx * 4);
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.set_reg(idx, v);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic set_idling();
        if (sent < 37)
        begin
            send_idle = 33;
            recv_idle = 46;
        end
        else if (sent < 74)
        begin
            send_idle = 46;
            recv_idle = 33;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send_item(cast_req_t it);
        in_ch.valid <= 1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(it);
        sent++;
        set_idling();
        if ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic map_write(int r, int unsigned bits);
        cast_req_t it;
        it = '0;
        it.req_type = REQ_MAP;
        it.map_row = 4'(r);
        it.map_bits = 16'(bits);
        send_item(it);
    endtask

    task automatic cast(int unsigned x, int unsigned y, int unsigned a, int unsigned c);
        cast_req_t it;
        it = cast_req_t'($urandom());
        it.req_type = REQ_CAST;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.view_angle = 16'(a);
        it.column = 7'(c);
        send_item(it);
    endtask

    // Lets the block drain before registers change.
    task automatic settle();
        in_ch.valid <= 0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_all(int unsigned w, int unsigned f, int unsigned d, int unsigned s);
        settle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_FOV, f);
        reg_write(REG_DEPTH, d);
        reg_write(REG_STEP, s);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
                map_write($urandom_range(15), $urandom() & $urandom());
            else if ($urandom_range(99) < 70)
                cast($urandom_range(4096, 61439), $urandom_range(4096, 61439),
                     $urandom_range(65535), $urandom_range(127));
            else
                cast($urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(127));
        end
    endtask

    initial
    begin
        int unsigned d;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        sb.set_reg(REG_WIDTH, 120);
        sb.set_reg(REG_FOV, 8192);
        sb.set_reg(REG_DEPTH, 16);
        sb.set_reg(REG_STEP, 410);
        @(posedge clk);

        // Walled border, a few pillars inside; every row written before any cast.
        for (int r = 0; r < 16; r++)
            map_write(r, (r == 0 || r == 15) ? 16'hFFFF :
                         ((r % 4 == 2) ? 16'h8421 : 16'h8001));
        cast(32768, 32768, 0, 0);
        cast(32768, 32768, 16384, 60);
        cast(32768, 32768, 32768, 119);
        cast(32768, 32768, 65535, 127);
        cast(0, 0, 0, 0);
        cast(65535, 65535, 49152, 64);
        cast(6144, 6144, 8192, 60);

        // Smallest settings: single column, zero field of view, depth 1, unit step.
        set_all(1, 0, 1, 1);
        cast(8192, 8192, 0, 0);
        cast(20000, 30000, 40000, 5);

        // Largest settings.
        set_all(128, 32768, 16, 4096);
        cast(32768, 32768, 0, 0);
        cast(32768, 32768, 24576, 127);
        cast(10000, 50000, 12345, 64);

        // Out-of-range values that saturate.
        set_all(0, 32768, 0, 0);
        cast(30000, 30000, 1000, 3);
        set_all(255, 65535, 31, 8191);
        cast(30000, 30000, 50000, 100);
        cast(30000, 30000, 20000, 127);

        // Random settings and items.
        for (int p = 0; p < 6; p++)
        begin
            d = $urandom_range(1, 16);
            set_all($urandom_range(1, 128), $urandom_range(32768), d,
                    $urandom_range(d * 20, 4096));
            random_phase(13);
        end

        settle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
